@@ design/rie_pkg.sv @@
// Shared types, codes and constants of the integer execute unit.
package rie_pkg;

    localparam int NUM_REGS    = 32;
    localparam int DATA_WIDTH  = 32;
    localparam int REG_IDX_W   = $clog2(NUM_REGS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int MD_STEPS    = DATA_WIDTH;
    localparam int MD_CNT_W    = $clog2(MD_STEPS);

    // Primary opcodes.
    localparam logic [5:0] OPC_SPECIAL = 6'h00;
    localparam logic [5:0] OPC_REGIMM  = 6'h01;
    localparam logic [5:0] OPC_J       = 6'h02;
    localparam logic [5:0] OPC_JAL     = 6'h03;
    localparam logic [5:0] OPC_BEQ     = 6'h04;
    localparam logic [5:0] OPC_BNE     = 6'h05;
    localparam logic [5:0] OPC_BLEZ    = 6'h06;
    localparam logic [5:0] OPC_BGTZ    = 6'h07;
    localparam logic [5:0] OPC_ADDI    = 6'h08;
    localparam logic [5:0] OPC_ADDIU   = 6'h09;
    localparam logic [5:0] OPC_SLTI    = 6'h0A;
    localparam logic [5:0] OPC_SLTIU   = 6'h0B;
    localparam logic [5:0] OPC_ANDI    = 6'h0C;
    localparam logic [5:0] OPC_ORI     = 6'h0D;
    localparam logic [5:0] OPC_XORI    = 6'h0E;
    localparam logic [5:0] OPC_LUI     = 6'h0F;
    localparam logic [5:0] OPC_LB      = 6'h20;
    localparam logic [5:0] OPC_LH      = 6'h21;
    localparam logic [5:0] OPC_LW      = 6'h23;
    localparam logic [5:0] OPC_LBU     = 6'h24;
    localparam logic [5:0] OPC_LHU     = 6'h25;
    localparam logic [5:0] OPC_SB      = 6'h28;
    localparam logic [5:0] OPC_SH      = 6'h29;
    localparam logic [5:0] OPC_SW      = 6'h2B;

    // Function codes of the special opcode.
    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_SLLV  = 6'h04;
    localparam logic [5:0] FN_SRLV  = 6'h06;
    localparam logic [5:0] FN_SRAV  = 6'h07;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_JALR  = 6'h09;
    localparam logic [5:0] FN_MFHI  = 6'h10;
    localparam logic [5:0] FN_MTHI  = 6'h11;
    localparam logic [5:0] FN_MFLO  = 6'h12;
    localparam logic [5:0] FN_MTLO  = 6'h13;
    localparam logic [5:0] FN_MULT  = 6'h18;
    localparam logic [5:0] FN_MULTU = 6'h19;
    localparam logic [5:0] FN_DIV   = 6'h1A;
    localparam logic [5:0] FN_DIVU  = 6'h1B;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_SUBU  = 6'h23;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_SLT   = 6'h2A;
    localparam logic [5:0] FN_SLTU  = 6'h2B;

    // Branch codes in the rt field of the REGIMM opcode.
    localparam logic [4:0] RI_BLTZ   = 5'h00;
    localparam logic [4:0] RI_BGEZ   = 5'h01;
    localparam logic [4:0] RI_BLTZAL = 5'h10;
    localparam logic [4:0] RI_BGEZAL = 5'h11;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    localparam logic [2:0] SIZE_BYTE = 3'd1;
    localparam logic [2:0] SIZE_HALF = 3'd2;
    localparam logic [2:0] SIZE_WORD = 3'd4;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_INVALID  = 2'd2;

    localparam logic [REG_IDX_W-1:0] LINK_REG = REG_IDX_W'(31);

    typedef enum logic [5:0] {
        OP_SLL, OP_SRL, OP_SRA, OP_SLLV, OP_SRLV, OP_SRAV,
        OP_JR, OP_JALR, OP_MFHI, OP_MTHI, OP_MFLO, OP_MTLO,
        OP_MULT, OP_MULTU, OP_DIV, OP_DIVU,
        OP_ADD, OP_ADDU, OP_SUB, OP_SUBU, OP_AND, OP_OR, OP_XOR, OP_SLT, OP_SLTU,
        OP_BLTZ, OP_BGEZ, OP_BLTZAL, OP_BGEZAL, OP_J, OP_JAL,
        OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ,
        OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI,
        OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW,
        OP_INVALID, OP_LDRET
    } op_t;

    typedef enum logic [2:0] {
        LK_NONE = 3'd0,
        LK_LB   = 3'd1,
        LK_LBU  = 3'd2,
        LK_LH   = 3'd3,
        LK_LHU  = 3'd4,
        LK_LW   = 3'd5
    } lk_t;

    // One classified item: word is the instruction, or the load data for a return.
    typedef struct packed {
        op_t                   op;
        logic [DATA_WIDTH-1:0] word;
        logic [DATA_WIDTH-1:0] npc;
    } item_t;

    typedef struct packed {
        logic                  branch_taken;
        logic [DATA_WIDTH-1:0] target_address;
        logic                  reg_write;
        logic [REG_IDX_W-1:0]  write_reg;
        logic [DATA_WIDTH-1:0] write_value;
        logic [1:0]            mem_request;
        logic [DATA_WIDTH-1:0] mem_address;
        logic [2:0]            mem_size;
        logic [DATA_WIDTH-1:0] store_data;
        logic [1:0]            error_code;
    } result_t;

    typedef struct packed {
        logic                  start;
        logic                  is_div;
        logic                  is_signed;
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
    } md_req_t;

    typedef struct packed {
        logic                  done;
        logic [DATA_WIDTH-1:0] hi;
        logic [DATA_WIDTH-1:0] lo;
    } md_rsp_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_MULDIV
    } bk_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_RUN,
        MD_FIX
    } md_state_t;

endpackage

@@ design/rie_if.sv @@
// Channel interfaces: instruction items in, result items out.
interface rie_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] instr_word;
    logic [31:0] next_pc;
    logic [31:0] load_data;

    modport source (output valid, mode, instr_word, next_pc, load_data, input ready);
    modport sink   (input valid, mode, instr_word, next_pc, load_data, output ready);
endinterface

interface rie_out_if;
    logic        valid;
    logic        ready;
    logic        branch_taken;
    logic [31:0] target_address;
    logic        reg_write;
    logic [4:0]  write_reg;
    logic [31:0] write_value;
    logic [1:0]  mem_request;
    logic [31:0] mem_address;
    logic [2:0]  mem_size;
    logic [31:0] store_data;
    logic [1:0]  error_code;

    modport source (output valid, branch_taken, target_address, reg_write, write_reg,
                    write_value, mem_request, mem_address, mem_size, store_data,
                    error_code, input ready);
    modport sink   (input valid, branch_taken, target_address, reg_write, write_reg,
                    write_value, mem_request, mem_address, mem_size, store_data,
                    error_code, output ready);
endinterface

@@ design/rie_front.sv @@
// Front end: takes input beats and classifies them into operation codes.
module rie_front (
    rie_in_if.sink          instr,
    output rie_pkg::item_t  push_item,
    output logic            push_valid,
    input  logic            push_ready
);

    rie_pkg::op_t op;
    logic [5:0]   opcode;
    logic [5:0]   funct;
    logic [4:0]   ri_code;

    assign opcode  = instr.instr_word[31:26];
    assign funct   = instr.instr_word[5:0];
    assign ri_code = instr.instr_word[20:16];

    always_comb
    begin
        op = rie_pkg::OP_INVALID;
        if (instr.mode)
        begin
            op = rie_pkg::OP_LDRET;
        end
        else
        begin
            unique case (opcode)
                rie_pkg::OPC_SPECIAL:
                begin
                    unique case (funct)
                        rie_pkg::FN_SLL:   op = rie_pkg::OP_SLL;
                        rie_pkg::FN_SRL:   op = rie_pkg::OP_SRL;
                        rie_pkg::FN_SRA:   op = rie_pkg::OP_SRA;
                        rie_pkg::FN_SLLV:  op = rie_pkg::OP_SLLV;
                        rie_pkg::FN_SRLV:  op = rie_pkg::OP_SRLV;
                        rie_pkg::FN_SRAV:  op = rie_pkg::OP_SRAV;
                        rie_pkg::FN_JR:    op = rie_pkg::OP_JR;
                        rie_pkg::FN_JALR:  op = rie_pkg::OP_JALR;
                        rie_pkg::FN_MFHI:  op = rie_pkg::OP_MFHI;
                        rie_pkg::FN_MTHI:  op = rie_pkg::OP_MTHI;
                        rie_pkg::FN_MFLO:  op = rie_pkg::OP_MFLO;
                        rie_pkg::FN_MTLO:  op = rie_pkg::OP_MTLO;
                        rie_pkg::FN_MULT:  op = rie_pkg::OP_MULT;
                        rie_pkg::FN_MULTU: op = rie_pkg::OP_MULTU;
                        rie_pkg::FN_DIV:   op = rie_pkg::OP_DIV;
                        rie_pkg::FN_DIVU:  op = rie_pkg::OP_DIVU;
                        rie_pkg::FN_ADD:   op = rie_pkg::OP_ADD;
                        rie_pkg::FN_ADDU:  op = rie_pkg::OP_ADDU;
                        rie_pkg::FN_SUB:   op = rie_pkg::OP_SUB;
                        rie_pkg::FN_SUBU:  op = rie_pkg::OP_SUBU;
                        rie_pkg::FN_AND:   op = rie_pkg::OP_AND;
                        rie_pkg::FN_OR:    op = rie_pkg::OP_OR;
                        rie_pkg::FN_XOR:   op = rie_pkg::OP_XOR;
                        rie_pkg::FN_SLT:   op = rie_pkg::OP_SLT;
                        rie_pkg::FN_SLTU:  op = rie_pkg::OP_SLTU;
                        default:           op = rie_pkg::OP_INVALID;
                    endcase
                end
                rie_pkg::OPC_REGIMM:
                begin
                    unique case (ri_code)
                        rie_pkg::RI_BLTZ:   op = rie_pkg::OP_BLTZ;
                        rie_pkg::RI_BGEZ:   op = rie_pkg::OP_BGEZ;
                        rie_pkg::RI_BLTZAL: op = rie_pkg::OP_BLTZAL;
                        rie_pkg::RI_BGEZAL: op = rie_pkg::OP_BGEZAL;
                        default:            op = rie_pkg::OP_INVALID;
                    endcase
                end
                rie_pkg::OPC_J:     op = rie_pkg::OP_J;
                rie_pkg::OPC_JAL:   op = rie_pkg::OP_JAL;
                rie_pkg::OPC_BEQ:   op = rie_pkg::OP_BEQ;
                rie_pkg::OPC_BNE:   op = rie_pkg::OP_BNE;
                rie_pkg::OPC_BLEZ:  op = rie_pkg::OP_BLEZ;
                rie_pkg::OPC_BGTZ:  op = rie_pkg::OP_BGTZ;
                rie_pkg::OPC_ADDI:  op = rie_pkg::OP_ADDI;
                rie_pkg::OPC_ADDIU: op = rie_pkg::OP_ADDIU;
                rie_pkg::OPC_SLTI:  op = rie_pkg::OP_SLTI;
                rie_pkg::OPC_SLTIU: op = rie_pkg::OP_SLTIU;
                rie_pkg::OPC_ANDI:  op = rie_pkg::OP_ANDI;
                rie_pkg::OPC_ORI:   op = rie_pkg::OP_ORI;
                rie_pkg::OPC_XORI:  op = rie_pkg::OP_XORI;
                rie_pkg::OPC_LUI:   op = rie_pkg::OP_LUI;
                rie_pkg::OPC_LB:    op = rie_pkg::OP_LB;
                rie_pkg::OPC_LH:    op = rie_pkg::OP_LH;
                rie_pkg::OPC_LW:    op = rie_pkg::OP_LW;
                rie_pkg::OPC_LBU:   op = rie_pkg::OP_LBU;
                rie_pkg::OPC_LHU:   op = rie_pkg::OP_LHU;
                rie_pkg::OPC_SB:    op = rie_pkg::OP_SB;
                rie_pkg::OPC_SH:    op = rie_pkg::OP_SH;
                rie_pkg::OPC_SW:    op = rie_pkg::OP_SW;
                default:            op = rie_pkg::OP_INVALID;
            endcase
        end
    end

    assign push_item.op   = op;
    assign push_item.word = instr.mode ? instr.load_data : instr.instr_word;
    assign push_item.npc  = instr.next_pc;
    assign push_valid     = instr.valid;
    assign instr.ready    = push_ready;

endmodule

@@ design/rie_queue.sv @@
// Short queue of classified items between the front end and the back end.
module rie_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  rie_pkg::item_t  push_item,
    output logic            push_ready,
    input  logic            pop,
    output rie_pkg::item_t  head_item,
    output logic            head_valid
);

    localparam int DEPTH = rie_pkg::QUEUE_DEPTH;

    rie_pkg::item_t                entry_reg [DEPTH];
    logic [rie_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [rie_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [rie_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                          push;
    logic                          do_pop;

    assign push_ready = (count_reg != rie_pkg::QCNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == rie_pkg::QPTR_W'(DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == rie_pkg::QPTR_W'(DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // The fill count must never exceed the queue depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rie_pkg::QCNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ design/rie_muldiv.sv @@
// Iterative multiply and divide unit: one bit per cycle, sign fixed at the end.
module rie_muldiv (
    input  logic              clk,
    input  logic              rst_n,
    input  rie_pkg::md_req_t  req,
    output rie_pkg::md_rsp_t  rsp
);

    localparam int W = rie_pkg::DATA_WIDTH;

    rie_pkg::md_state_t            state_reg, state_next;
    logic [rie_pkg::MD_CNT_W-1:0]  cnt_reg;
    logic [W-1:0]                  hi_reg;
    logic [W-1:0]                  lo_reg;
    logic [W-1:0]                  operand_reg;
    logic                          is_div_reg;
    logic                          neg_q_reg;
    logic                          neg_r_reg;

    logic [W-1:0]   mag_a;
    logic [W-1:0]   mag_b;
    logic [W:0]     shifted;
    logic [W:0]     diff;
    logic [W:0]     sum;
    logic [2*W-1:0] prod;
    logic [2*W-1:0] prod_fix;

    assign mag_a = (req.is_signed && req.a[W-1]) ? (~req.a + 1'b1) : req.a;
    assign mag_b = (req.is_signed && req.b[W-1]) ? (~req.b + 1'b1) : req.b;

    // Restoring divide step on the remainder, shift-add step on the product.
    assign shifted = {hi_reg, lo_reg[W-1]};
    assign diff    = shifted - {1'b0, operand_reg};
    assign sum     = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, operand_reg} : '0);

    assign prod     = {hi_reg, lo_reg};
    assign prod_fix = neg_q_reg ? (~prod + 1'b1) : prod;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rie_pkg::MD_IDLE:
            begin
                if (req.start)
                begin
                    state_next = rie_pkg::MD_RUN;
                end
            end
            rie_pkg::MD_RUN:
            begin
                if (cnt_reg == rie_pkg::MD_CNT_W'(rie_pkg::MD_STEPS - 1))
                begin
                    state_next = rie_pkg::MD_FIX;
                end
            end
            rie_pkg::MD_FIX:
            begin
                state_next = rie_pkg::MD_IDLE;
            end
            default:
            begin
                state_next = rie_pkg::MD_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp.done = (state_reg == rie_pkg::MD_FIX);
        if (is_div_reg)
        begin
            rsp.hi = neg_r_reg ? (~hi_reg + 1'b1) : hi_reg;
            rsp.lo = neg_q_reg ? (~lo_reg + 1'b1) : lo_reg;
        end
        else
        begin
            rsp.hi = prod_fix[2*W-1:W];
            rsp.lo = prod_fix[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rie_pkg::MD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == rie_pkg::MD_IDLE)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == rie_pkg::MD_RUN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == rie_pkg::MD_IDLE && req.start)
        begin
            hi_reg      <= '0;
            lo_reg      <= req.is_div ? mag_a : mag_b;
            operand_reg <= req.is_div ? mag_b : mag_a;
            is_div_reg  <= req.is_div;
            neg_q_reg   <= req.is_signed && (req.a[W-1] ^ req.b[W-1]);
            neg_r_reg   <= req.is_signed && req.is_div && req.a[W-1];
        end
        else if (state_reg == rie_pkg::MD_RUN)
        begin
            if (is_div_reg)
            begin
                if (!diff[W])
                begin
                    hi_reg <= diff[W-1:0];
                    lo_reg <= {lo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    hi_reg <= shifted[W-1:0];
                    lo_reg <= {lo_reg[W-2:0], 1'b0};
                end
            end
            else
            begin
                hi_reg <= sum[W:1];
                lo_reg <= {sum[0], lo_reg[W-1:1]};
            end
        end
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == rie_pkg::MD_IDLE)
        else $error("multiply/divide started while busy");

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> $past(state_reg) == rie_pkg::MD_RUN)
        else $error("multiply/divide finished without iterating");

endmodule

@@ design/rie_back.sv @@
// Back end: register file, HI/LO, pending load, execution and result register.
module rie_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rie_pkg::item_t    head_item,
    input  logic              head_valid,
    output logic              pop,
    output rie_pkg::md_req_t  md_req,
    input  rie_pkg::md_rsp_t  md_rsp,
    rie_out_if.source         result
);

    localparam int W  = rie_pkg::DATA_WIDTH;
    localparam int RW = rie_pkg::REG_IDX_W;

    rie_pkg::bk_state_t   state_reg, state_next;
    rie_pkg::item_t       item_reg;
    logic [W-1:0]         rf_mem [rie_pkg::NUM_REGS];
    logic [rie_pkg::NUM_REGS-1:0] rf_valid_reg;
    logic [W-1:0]         a_data_reg, b_data_reg;
    logic                 a_ok_reg, b_ok_reg;
    logic [W-1:0]         hi_reg, lo_reg;
    logic [RW-1:0]        pend_dest_reg;
    rie_pkg::lk_t         pend_kind_reg;
    logic                 out_valid_reg;
    rie_pkg::result_t     out_reg;

    logic                 commit;
    logic                 out_free;
    logic                 md_needed;
    rie_pkg::result_t     res;
    logic                 wr_en;
    logic [RW-1:0]        wr_idx;
    logic [W-1:0]         wr_val;
    logic [1:0]           err;
    logic                 set_load;
    rie_pkg::lk_t         new_kind;
    logic                 clr_load;
    logic                 set_hi, set_lo;
    logic                 rf_we;

    logic [W-1:0] ins, npc, a, b, simm, zimm, btgt, jtgt, link, ea;
    logic [W-1:0] op2, add_r, sub_r, ldv;
    logic [RW-1:0] rs, rt, rd;
    logic [4:0]   shamt;
    logic         add_ovf, sub_ovf, neg;

    assign out_free = !out_valid_reg || result.ready;

    assign ins   = item_reg.word;
    assign npc   = item_reg.npc;
    assign rs    = ins[25:21];
    assign rt    = ins[20:16];
    assign rd    = ins[15:11];
    assign a     = a_ok_reg ? a_data_reg : '0;
    assign b     = b_ok_reg ? b_data_reg : '0;
    assign simm  = {{16{ins[15]}}, ins[15:0]};
    assign zimm  = {16'h0000, ins[15:0]};
    assign btgt  = npc + {simm[W-3:0], 2'b00};
    assign jtgt  = {npc[W-1:W-4], ins[25:0], 2'b00};
    assign link  = npc + W'(4);
    assign ea    = a + simm;
    assign neg   = a[W-1];
    assign op2   = (item_reg.op == rie_pkg::OP_ADDI) ? simm : b;
    assign add_r = a + op2;
    assign sub_r = a - b;
    assign add_ovf = ~(a[W-1] ^ op2[W-1]) & (a[W-1] ^ add_r[W-1]);
    assign sub_ovf = (a[W-1] ^ b[W-1]) & (a[W-1] ^ sub_r[W-1]);
    assign shamt = (item_reg.op == rie_pkg::OP_SLLV || item_reg.op == rie_pkg::OP_SRLV ||
                    item_reg.op == rie_pkg::OP_SRAV) ? a[4:0] : ins[10:6];

    always_comb
    begin
        case (pend_kind_reg)
            rie_pkg::LK_LB:  ldv = {{24{ins[7]}}, ins[7:0]};
            rie_pkg::LK_LBU: ldv = {24'h000000, ins[7:0]};
            rie_pkg::LK_LH:  ldv = {{16{ins[15]}}, ins[15:0]};
            rie_pkg::LK_LHU: ldv = {16'h0000, ins[15:0]};
            default:         ldv = ins;
        endcase
    end

    // Execute: the result of the held item, and the state changes it causes.
    always_comb
    begin
        res      = '0;
        wr_en    = 1'b0;
        wr_idx   = rd;
        wr_val   = '0;
        err      = rie_pkg::ERR_NONE;
        set_load = 1'b0;
        new_kind = rie_pkg::LK_NONE;
        clr_load = 1'b0;
        set_hi   = 1'b0;
        set_lo   = 1'b0;
        md_needed = 1'b0;
        case (item_reg.op)
            rie_pkg::OP_SLL:  begin wr_en = 1'b1; wr_val = b << shamt; end
            rie_pkg::OP_SRL:  begin wr_en = 1'b1; wr_val = b >> shamt; end
            rie_pkg::OP_SRA:  begin wr_en = 1'b1; wr_val = W'($signed(b) >>> shamt); end
            rie_pkg::OP_SLLV: begin wr_en = 1'b1; wr_val = b << shamt; end
            rie_pkg::OP_SRLV: begin wr_en = 1'b1; wr_val = b >> shamt; end
            rie_pkg::OP_SRAV: begin wr_en = 1'b1; wr_val = W'($signed(b) >>> shamt); end
            rie_pkg::OP_JR:
            begin
                res.branch_taken = 1'b1;
                res.target_address = a;
            end
            rie_pkg::OP_JALR:
            begin
                res.branch_taken = 1'b1;
                res.target_address = a;
                wr_en = 1'b1;
                wr_val = link;
            end
            rie_pkg::OP_MFHI: begin wr_en = 1'b1; wr_val = hi_reg; end
            rie_pkg::OP_MFLO: begin wr_en = 1'b1; wr_val = lo_reg; end
            rie_pkg::OP_MTHI: set_hi = 1'b1;
            rie_pkg::OP_MTLO: set_lo = 1'b1;
            rie_pkg::OP_MULT, rie_pkg::OP_MULTU: md_needed = 1'b1;
            rie_pkg::OP_DIV, rie_pkg::OP_DIVU:   md_needed = (b != '0);
            rie_pkg::OP_ADD:
            begin
                if (add_ovf)
                begin
                    err = rie_pkg::ERR_OVERFLOW;
                end
                wr_en = 1'b1;
                wr_val = add_r;
            end
            rie_pkg::OP_ADDU: begin wr_en = 1'b1; wr_val = add_r; end
            rie_pkg::OP_SUB:
            begin
                if (sub_ovf)
                begin
                    err = rie_pkg::ERR_OVERFLOW;
                end
                wr_en = 1'b1;
                wr_val = sub_r;
            end
            rie_pkg::OP_SUBU: begin wr_en = 1'b1; wr_val = sub_r; end
            rie_pkg::OP_AND:  begin wr_en = 1'b1; wr_val = a & b; end
            rie_pkg::OP_OR:   begin wr_en = 1'b1; wr_val = a | b; end
            rie_pkg::OP_XOR:  begin wr_en = 1'b1; wr_val = a ^ b; end
            rie_pkg::OP_SLT:
            begin
                wr_en = 1'b1;
                wr_val = W'($signed(a) < $signed(b));
            end
            rie_pkg::OP_SLTU: begin wr_en = 1'b1; wr_val = W'(a < b); end
            rie_pkg::OP_BLTZ, rie_pkg::OP_BLTZAL, rie_pkg::OP_BGEZ, rie_pkg::OP_BGEZAL:
            begin
                if (neg == (item_reg.op == rie_pkg::OP_BLTZ ||
                            item_reg.op == rie_pkg::OP_BLTZAL))
                begin
                    res.branch_taken = 1'b1;
                    res.target_address = btgt;
                end
                // The linking forms write the return address whether taken or not.
                if (item_reg.op == rie_pkg::OP_BLTZAL || item_reg.op == rie_pkg::OP_BGEZAL)
                begin
                    wr_en = 1'b1;
                    wr_idx = rie_pkg::LINK_REG;
                    wr_val = link;
                end
            end
            rie_pkg::OP_J:
            begin
                res.branch_taken = 1'b1;
                res.target_address = jtgt;
            end
            rie_pkg::OP_JAL:
            begin
                res.branch_taken = 1'b1;
                res.target_address = jtgt;
                wr_en = 1'b1;
                wr_idx = rie_pkg::LINK_REG;
                wr_val = link;
            end
            rie_pkg::OP_BEQ, rie_pkg::OP_BNE, rie_pkg::OP_BLEZ, rie_pkg::OP_BGTZ:
            begin
                if ((item_reg.op == rie_pkg::OP_BEQ  && a == b) ||
                    (item_reg.op == rie_pkg::OP_BNE  && a != b) ||
                    (item_reg.op == rie_pkg::OP_BLEZ && (neg || a == '0)) ||
                    (item_reg.op == rie_pkg::OP_BGTZ && !neg && a != '0))
                begin
                    res.branch_taken = 1'b1;
                    res.target_address = btgt;
                end
            end
            rie_pkg::OP_ADDI:
            begin
                if (add_ovf)
                begin
                    err = rie_pkg::ERR_OVERFLOW;
                end
                wr_en = 1'b1;
                wr_idx = rt;
                wr_val = add_r;
            end
            rie_pkg::OP_ADDIU: begin wr_en = 1'b1; wr_idx = rt; wr_val = a + simm; end
            rie_pkg::OP_SLTI:
            begin
                wr_en = 1'b1;
                wr_idx = rt;
                wr_val = W'($signed(a) < $signed(simm));
            end
            rie_pkg::OP_SLTIU: begin wr_en = 1'b1; wr_idx = rt; wr_val = W'(a < simm); end
            rie_pkg::OP_ANDI:  begin wr_en = 1'b1; wr_idx = rt; wr_val = a & zimm; end
            rie_pkg::OP_ORI:   begin wr_en = 1'b1; wr_idx = rt; wr_val = a | zimm; end
            rie_pkg::OP_XORI:  begin wr_en = 1'b1; wr_idx = rt; wr_val = a ^ zimm; end
            rie_pkg::OP_LUI:
            begin
                wr_en = 1'b1;
                wr_idx = rt;
                wr_val = {ins[15:0], 16'h0000};
            end
            rie_pkg::OP_LB, rie_pkg::OP_LBU, rie_pkg::OP_LH, rie_pkg::OP_LHU,
            rie_pkg::OP_LW:
            begin
                res.mem_request = rie_pkg::MEM_LOAD;
                res.mem_address = ea;
                set_load = 1'b1;
                case (item_reg.op)
                    rie_pkg::OP_LB:
                    begin
                        res.mem_size = rie_pkg::SIZE_BYTE;
                        new_kind = rie_pkg::LK_LB;
                    end
                    rie_pkg::OP_LBU:
                    begin
                        res.mem_size = rie_pkg::SIZE_BYTE;
                        new_kind = rie_pkg::LK_LBU;
                    end
                    rie_pkg::OP_LH:
                    begin
                        res.mem_size = rie_pkg::SIZE_HALF;
                        new_kind = rie_pkg::LK_LH;
                    end
                    rie_pkg::OP_LHU:
                    begin
                        res.mem_size = rie_pkg::SIZE_HALF;
                        new_kind = rie_pkg::LK_LHU;
                    end
                    default:
                    begin
                        res.mem_size = rie_pkg::SIZE_WORD;
                        new_kind = rie_pkg::LK_LW;
                    end
                endcase
            end
            rie_pkg::OP_SB, rie_pkg::OP_SH, rie_pkg::OP_SW:
            begin
                res.mem_request = rie_pkg::MEM_STORE;
                res.mem_address = ea;
                res.store_data = b;
                res.mem_size = (item_reg.op == rie_pkg::OP_SB) ? rie_pkg::SIZE_BYTE
                             : (item_reg.op == rie_pkg::OP_SH) ? rie_pkg::SIZE_HALF
                             : rie_pkg::SIZE_WORD;
            end
            rie_pkg::OP_LDRET:
            begin
                if (pend_kind_reg != rie_pkg::LK_NONE)
                begin
                    wr_en = 1'b1;
                    wr_idx = pend_dest_reg;
                    wr_val = ldv;
                    clr_load = 1'b1;
                end
            end
            default: err = rie_pkg::ERR_INVALID;
        endcase

        // Register zero is never written and the write is not reported.
        if (wr_en && wr_idx != '0)
        begin
            res.reg_write = 1'b1;
            res.write_reg = wr_idx;
            res.write_value = wr_val;
        end
        else
        begin
            wr_en = 1'b0;
        end

        if (err != rie_pkg::ERR_NONE)
        begin
            res = '0;
            res.error_code = err;
            wr_en = 1'b0;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rie_pkg::BK_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = rie_pkg::BK_EXEC;
                end
            end
            rie_pkg::BK_EXEC:
            begin
                if (out_free)
                begin
                    state_next = md_needed ? rie_pkg::BK_MULDIV : rie_pkg::BK_IDLE;
                end
            end
            rie_pkg::BK_MULDIV:
            begin
                if (md_rsp.done)
                begin
                    state_next = rie_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = rie_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop    = (state_reg == rie_pkg::BK_IDLE) && head_valid;
        commit = (state_reg == rie_pkg::BK_EXEC) && out_free;
        rf_we  = commit && wr_en;
        md_req.start     = commit && md_needed;
        md_req.is_div    = (item_reg.op == rie_pkg::OP_DIV || item_reg.op == rie_pkg::OP_DIVU);
        md_req.is_signed = (item_reg.op == rie_pkg::OP_DIV || item_reg.op == rie_pkg::OP_MULT);
        md_req.a         = a;
        md_req.b         = b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rie_pkg::BK_IDLE;
            rf_valid_reg  <= '0;
            a_ok_reg      <= 1'b0;
            b_ok_reg      <= 1'b0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            pend_dest_reg <= '0;
            pend_kind_reg <= rie_pkg::LK_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                a_ok_reg <= rf_valid_reg[head_item.word[25:21]];
                b_ok_reg <= rf_valid_reg[head_item.word[20:16]];
            end
            if (rf_we)
            begin
                rf_valid_reg[wr_idx] <= 1'b1;
            end
            if (commit && set_hi)
            begin
                hi_reg <= a;
            end
            else if (md_rsp.done)
            begin
                hi_reg <= md_rsp.hi;
            end
            if (commit && set_lo)
            begin
                lo_reg <= a;
            end
            else if (md_rsp.done)
            begin
                lo_reg <= md_rsp.lo;
            end
            if (commit && set_load && err == rie_pkg::ERR_NONE)
            begin
                pend_kind_reg <= new_kind;
                pend_dest_reg <= rt;
            end
            else if (commit && clr_load)
            begin
                pend_kind_reg <= rie_pkg::LK_NONE;
                pend_dest_reg <= '0;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head_item;
        end
        if (commit)
        begin
            out_reg <= res;
        end
    end

    // Register file storage: registered reads at pop, one write at commit.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_data_reg <= rf_mem[head_item.word[25:21]];
            b_data_reg <= rf_mem[head_item.word[20:16]];
        end
        if (rf_we)
        begin
            rf_mem[wr_idx] <= wr_val;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.branch_taken   = out_reg.branch_taken;
    assign result.target_address = out_reg.target_address;
    assign result.reg_write      = out_reg.reg_write;
    assign result.write_reg      = out_reg.write_reg;
    assign result.write_value    = out_reg.write_value;
    assign result.mem_request    = out_reg.mem_request;
    assign result.mem_address    = out_reg.mem_address;
    assign result.mem_size       = out_reg.mem_size;
    assign result.store_data     = out_reg.store_data;
    assign result.error_code     = out_reg.error_code;

    a_no_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |-> wr_idx != '0)
        else $error("write to register zero");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.error_code != rie_pkg::ERR_NONE
        |-> !result.reg_write && result.mem_request == rie_pkg::MEM_NONE
            && !result.branch_taken)
        else $error("error beat carries side effects");

    a_md_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> state_reg == rie_pkg::BK_MULDIV)
        else $error("multiply/divide result with no item waiting");

endmodule

@@ design/risc_integer_execute_unit.sv @@
// Top level of the integer execute unit: front end, queue, back end, multiply/divide.
//
//   channel  direction  handshake      payload
//   instr    in         valid/ready    mode, instr_word, next_pc, load_data
//   result   out        valid/ready    branch/target, write-back, memory request, error
//
// The back end reads an item's operands at pop, then executes it and loads the result
// once the result register is free. mult, multu, div and divu with a nonzero divisor
// then wait on the iterative multiply/divide unit: one bit per cycle, then a sign fix-up.
// Reset clears all control state; register valid bits make the register file read
// as zero at once, so there is no clearing pass.
// The two-entry queue takes beats until full while the back end stalls on a held result.
module risc_integer_execute_unit (
    input  logic       clk,
    input  logic       rst_n,
    rie_in_if.sink     instr,
    rie_out_if.source  result
);

    rie_pkg::item_t    push_item;
    logic              push_valid;
    logic              push_ready;
    rie_pkg::item_t    head_item;
    logic              head_valid;
    logic              pop;
    rie_pkg::md_req_t  md_req;
    rie_pkg::md_rsp_t  md_rsp;

    rie_front u_front (
        .instr      (instr),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    rie_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop        (pop),
        .head_item  (head_item),
        .head_valid (head_valid)
    );

    rie_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    rie_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_item  (head_item),
        .head_valid (head_valid),
        .pop        (pop),
        .md_req     (md_req),
        .md_rsp     (md_rsp),
        .result     (result)
    );

endmodule
